// ----- src/wcet_pkg.sv -----
// Shared types and constants for the wall collision event tracker.
// Depends on nothing; imported by every module of the block except wcet_ram.
`default_nettype none

package wcet_pkg;

  localparam int NUM_SLOTS = 4096;
  localparam int SLOT_W    = $clog2(NUM_SLOTS);

  localparam logic [3:0]  GAS_SPECIES     = 4'd1;
  localparam logic [31:0] CUT_HEIGHT_INIT = 32'sd655360;

  localparam logic KIND_ENTRY = 1'b0;
  localparam logic KIND_EXIT  = 1'b1;

  typedef enum logic [1:0] {
    ST_CLEAR,
    ST_IDLE,
    ST_LOOKUP
  } state_t;

  typedef struct packed {
    logic [11:0]        molecule_slot;
    logic [3:0]         species;
    logic               first_frame;
    logic [23:0]        frame_time;
    logic signed [31:0] pos_x;
    logic signed [31:0] pos_y;
    logic signed [31:0] pos_z;
    logic signed [31:0] vel_x;
    logic signed [31:0] vel_y;
    logic signed [31:0] vel_z;
  } sample_t;

  typedef struct packed {
    logic               record_kind;
    logic [23:0]        event_time;
    logic signed [31:0] event_x;
    logic signed [31:0] event_y;
    logic signed [31:0] event_z;
    logic signed [31:0] event_vx;
    logic signed [31:0] event_vy;
    logic signed [31:0] event_vz;
    logic signed [31:0] penetration_min;
    logic               last;
  } record_t;

  // One stored sample of a molecule.
  typedef struct packed {
    logic [23:0]        ftime;
    logic signed [31:0] px;
    logic signed [31:0] py;
    logic signed [31:0] pz;
    logic signed [31:0] vx;
    logic signed [31:0] vy;
    logic signed [31:0] vz;
  } snap_t;

  // Everything kept for one slot, held in a single memory word.
  typedef struct packed {
    logic               was_above;
    logic               in_collision;
    snap_t              prev;
    snap_t              entry;
    logic signed [31:0] lowest_z;
  } slot_state_t;

  localparam int STATE_W = $bits(slot_state_t);

endpackage

`default_nettype wire

// ----- src/wall_collision_event_tracker_top.sv -----
// Wall collision event tracker: per-slot crossing detection over a state memory.
// Depends on wcet_pkg and wcet_ram.
//
// Usage:
//   in_valid/in_ready carry one molecule sample (sample_t) per request.
//   out_valid/out_ready carry result records (record_t). A molecule that
//   rises back above the cutoff after a dip gives two records, the entry
//   record and then the exit record (last set on the exit record only).
//   cfg_we/cfg_wdata write the cutoff height; write it only while idle.
// Timing:
//   A gas sample is handled in two steps: the request is taken and its slot read
//   from the state memory; then, in the lookup state, the word is updated and
//   written back, unless a stall holds it there. Samples of other species are
//   taken in the idle state alone. The registered read of the slot memory calls for the lookup step.
//   Results are registered in the update cycle; the two records of a pair leave
//   one after the other, entry first, when out_ready is held high.
// Reset and stalls:
//   After reset the slot memory is cleared one slot per cycle, all 4096 slots;
//   in_ready stays low until it is done.
//   A new sample is taken while records still wait; if that sample itself
//   produces records, it waits in its update cycle until both output
//   registers have drained.
`default_nettype none

module wall_collision_event_tracker_top
  import wcet_pkg::*;
(
  input  wire logic    clk,
  input  wire logic    rst,
  input  wire logic    cfg_we,
  input  wire logic [31:0] cfg_wdata,
  input  wire logic    in_valid,
  output logic         in_ready,
  input  wire sample_t in_data,
  output logic         out_valid,
  input  wire logic    out_ready,
  output record_t      out_data
);

  state_t            state;
  state_t            state_next;
  logic [SLOT_W-1:0] clr_addr;
  logic [31:0]       cut_height;
  sample_t           req;
  record_t           pend;
  logic              pend_valid;

  logic              take;
  logic              useful;
  logic              ram_we;
  logic              ram_re;
  logic [SLOT_W-1:0] ram_waddr;
  logic [STATE_W-1:0] ram_wdata;
  logic [STATE_W-1:0] ram_rdata;

  slot_state_t       cur;
  slot_state_t       upd;
  snap_t             now_snap;
  logic              above;
  logic              emit;
  logic              stall;
  logic signed [31:0] low_tmp;
  record_t           entry_rec;
  record_t           exit_rec;

  assign useful = (in_data.species == GAS_SPECIES)
                  && (32'(in_data.molecule_slot) < NUM_SLOTS);
  assign take   = in_valid && in_ready;
  assign ram_re = take && useful;

  wcet_ram #(
    .WIDTH(STATE_W),
    .DEPTH(NUM_SLOTS)
  ) u_state_ram (
    .clk  (clk),
    .we   (ram_we),
    .waddr(ram_waddr),
    .wdata(ram_wdata),
    .re   (ram_re),
    .raddr(in_data.molecule_slot[SLOT_W-1:0]),
    .rdata(ram_rdata)
  );

  // Slot update, evaluated in the lookup cycle from the word just read.
  always_comb begin
    cur      = slot_state_t'(ram_rdata);
    now_snap = '{ftime: req.frame_time, px: req.pos_x, py: req.pos_y,
                 pz: req.pos_z, vx: req.vel_x, vy: req.vel_y, vz: req.vel_z};
    above    = $signed(req.pos_z) >= $signed(cut_height);
    upd      = cur;
    emit     = 1'b0;
    low_tmp  = cur.lowest_z;
    if (req.first_frame) begin
      if (above) begin
        upd.was_above = 1'b1;
      end
    end else if (!above) begin
      if (cur.was_above) begin
        upd.in_collision = 1'b1;
        upd.entry        = cur.prev;
        low_tmp          = cur.prev.pz;
      end
      upd.was_above = 1'b0;
      // The depth is tracked against the previous sample's height.
      if (low_tmp >= cur.prev.pz) begin
        upd.lowest_z = cur.prev.pz;
      end else begin
        upd.lowest_z = low_tmp;
      end
    end else begin
      if (cur.in_collision) begin
        emit             = 1'b1;
        upd.in_collision = 1'b0;
      end
      upd.was_above = 1'b1;
    end
    upd.prev = now_snap;

    entry_rec = '{record_kind: KIND_ENTRY, event_time: cur.entry.ftime,
                  event_x: cur.entry.px, event_y: cur.entry.py,
                  event_z: cur.entry.pz, event_vx: cur.entry.vx,
                  event_vy: cur.entry.vy, event_vz: cur.entry.vz,
                  penetration_min: 32'sd0, last: 1'b0};
    exit_rec  = '{record_kind: KIND_EXIT, event_time: req.frame_time,
                  event_x: req.pos_x, event_y: req.pos_y, event_z: req.pos_z,
                  event_vx: req.vel_x, event_vy: req.vel_y, event_vz: req.vel_z,
                  penetration_min: cur.lowest_z, last: 1'b1};
  end

  assign stall = emit && (out_valid || pend_valid);

  // Next state and memory control.
  always_comb begin
    state_next = state;
    in_ready   = 1'b0;
    ram_we     = 1'b0;
    ram_waddr  = req.molecule_slot[SLOT_W-1:0];
    ram_wdata  = STATE_W'(upd);
    unique case (state)
      ST_CLEAR: begin
        ram_we    = 1'b1;
        ram_waddr = clr_addr;
        ram_wdata = '0;
        if (32'(clr_addr) == NUM_SLOTS - 1) begin
          state_next = ST_IDLE;
        end
      end
      ST_IDLE: begin
        in_ready = 1'b1;
        if (in_valid && useful) begin
          state_next = ST_LOOKUP;
        end
      end
      ST_LOOKUP: begin
        if (!stall) begin
          ram_we     = 1'b1;
          state_next = ST_IDLE;
        end
      end
      default: begin
        state_next = ST_CLEAR;
      end
    endcase
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      state    <= ST_CLEAR;
      clr_addr <= '0;
    end else begin
      state <= state_next;
      if (state == ST_CLEAR) begin
        clr_addr <= clr_addr + 1'b1;
      end
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      cut_height <= CUT_HEIGHT_INIT;
    end else if (cfg_we) begin
      cut_height <= cfg_wdata;
    end
  end

  always_ff @(posedge clk) begin
    if (take) begin
      req <= in_data;
    end
  end

  // Output register plus one waiting exit record.
  always_ff @(posedge clk) begin
    if (rst) begin
      out_valid  <= 1'b0;
      pend_valid <= 1'b0;
    end else if (state == ST_LOOKUP && emit && !stall) begin
      out_valid  <= 1'b1;
      pend_valid <= 1'b1;
    end else if (out_valid && out_ready) begin
      out_valid  <= pend_valid;
      pend_valid <= 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (state == ST_LOOKUP && emit && !stall) begin
      out_data <= entry_rec;
      pend     <= exit_rec;
    end else if (out_valid && out_ready && pend_valid) begin
      out_data <= pend;
    end
  end

endmodule

`default_nettype wire

// ----- src/wcet_ram.sv -----
// Generic simple dual-port RAM: one write port, one read port, registered read.
// No dependencies.
`default_nettype none

module wcet_ram #(
  parameter int WIDTH = 8,
  parameter int DEPTH = 16
) (
  input  wire logic                     clk,
  input  wire logic                     we,
  input  wire logic [$clog2(DEPTH)-1:0] waddr,
  input  wire logic [WIDTH-1:0]         wdata,
  input  wire logic                     re,
  input  wire logic [$clog2(DEPTH)-1:0] raddr,
  output logic      [WIDTH-1:0]         rdata
);

  logic [WIDTH-1:0] mem [DEPTH];

  always_ff @(posedge clk) begin
    if (we) begin
      mem[waddr] <= wdata;
    end
  end

  // Read data holds its value until the next read is issued.
  always_ff @(posedge clk) begin
    if (re) begin
      rdata <= mem[raddr];
    end
  end

endmodule

`default_nettype wire

// ----- src/wcet_checker.sv -----
// Port-level checks for the wall collision event tracker, bound to the top.
// Depends on wcet_pkg.
`default_nettype none

module wcet_checker
  import wcet_pkg::*;
(
  input wire logic    clk,
  input wire logic    rst,
  input wire logic    in_valid,
  input wire logic    in_ready,
  input wire sample_t in_data,
  input wire logic    out_valid,
  input wire logic    out_ready,
  input wire record_t out_data
);

  // The slot memory is being cleared straight after reset.
  a_clear_after_reset: assert property (@(posedge clk)
    rst |=> !in_ready)
    else $error("request taken during the clearing pass");

  // A gas sample needs its update cycle before the next request.
  a_gas_takes_two: assert property (@(posedge clk) disable iff (rst)
    (in_valid && in_ready && in_data.species == GAS_SPECIES) |=> !in_ready)
    else $error("request taken during a slot update");

  // An entry record is always followed at once by its exit record.
  a_pair_order: assert property (@(posedge clk) disable iff (rst)
    (out_valid && out_ready && out_data.record_kind == KIND_ENTRY)
      |=> (out_valid && out_data.record_kind == KIND_EXIT))
    else $error("entry record not followed by its exit record");

  // Only the exit record closes a pair.
  a_last_marks_exit: assert property (@(posedge clk) disable iff (rst)
    out_valid |-> (out_data.last == out_data.record_kind))
    else $error("last flag does not match the record kind");

  a_out_hold: assert property (@(posedge clk) disable iff (rst)
    (out_valid && !out_ready) |=> (out_valid && $stable(out_data)))
    else $error("stalled result changed");

endmodule

bind wall_collision_event_tracker_top wcet_checker u_wcet_checker (
  .clk      (clk),
  .rst      (rst),
  .in_valid (in_valid),
  .in_ready (in_ready),
  .in_data  (in_data),
  .out_valid(out_valid),
  .out_ready(out_ready),
  .out_data (out_data)
);

`default_nettype wire

// ----- tb/sv/wcet_event_checker.sv -----
// Checker for the wall collision event tracker: watches both channels and the cutoff write.
// It keeps its own per-slot crossing state and compares every record field by field.
// Depends on wcet_pkg for the sample and record types.
module wcet_event_checker
  import wcet_pkg::*;
(
  input  wire logic        clk,
  input  wire logic        rst,
  input  wire logic        cfg_we,
  input  wire logic [31:0] cfg_wdata,
  input  wire logic        in_valid,
  input  wire logic        in_ready,
  input  wire sample_t     in_data,
  input  wire logic        out_valid,
  input  wire logic        out_ready,
  input  wire record_t     out_data,
  output int               mismatches,
  output int               records_owed
);
  timeunit 1ns;
  timeprecision 1ps;

  typedef struct packed {
    logic               above;
    logic               dipping;
    sample_t            last_seen;
    sample_t            entry_pt;
    logic signed [31:0] deepest;
  } molecule_track_t;

  molecule_track_t    track [NUM_SLOTS];
  logic signed [31:0] cut_level;
  record_t            records_due [$];

  initial begin
    mismatches   = 0;
    records_owed = 0;
  end

  task automatic report_mismatch(input string msg);
    mismatches++;
    $display("%0t ns record check: %s", $time, msg);
  endtask

  task automatic check_field(input string name, input logic [31:0] got,
                             input logic [31:0] want);
    if (got !== want) begin
      report_mismatch($sformatf("%s is %h, should be %h", name, got, want));
    end
  endtask

  task automatic predict_records(input sample_t s);
    molecule_track_t t;
    record_t         r;
    logic            above;
    if (s.species != GAS_SPECIES || int'(s.molecule_slot) >= NUM_SLOTS) return;
    t = track[s.molecule_slot];
    above = $signed(s.pos_z) >= cut_level;
    if (s.first_frame) begin
      if (above) t.above = 1'b1;
    end else if (!above) begin
      // A drop from above opens a collision; the sample before the drop is the entry.
      if (t.above) begin
        t.dipping  = 1'b1;
        t.entry_pt = t.last_seen;
        t.deepest  = t.last_seen.pos_z;
      end
      t.above = 1'b0;
      // The depth is tracked one sample behind, on the previous height.
      if ($signed(t.deepest) >= $signed(t.last_seen.pos_z)) t.deepest = t.last_seen.pos_z;
    end else begin
      if (t.dipping) begin
        r                 = '0;
        r.record_kind     = KIND_ENTRY;
        r.event_time      = t.entry_pt.frame_time;
        r.event_x         = t.entry_pt.pos_x;
        r.event_y         = t.entry_pt.pos_y;
        r.event_z         = t.entry_pt.pos_z;
        r.event_vx        = t.entry_pt.vel_x;
        r.event_vy        = t.entry_pt.vel_y;
        r.event_vz        = t.entry_pt.vel_z;
        records_due       = {records_due, r};
        r.record_kind     = KIND_EXIT;
        r.event_time      = s.frame_time;
        r.event_x         = s.pos_x;
        r.event_y         = s.pos_y;
        r.event_z         = s.pos_z;
        r.event_vx        = s.vel_x;
        r.event_vy        = s.vel_y;
        r.event_vz        = s.vel_z;
        r.penetration_min = t.deepest;
        r.last            = 1'b1;
        records_due       = {records_due, r};
        t.dipping = 1'b0;
      end
      t.above = 1'b1;
    end
    t.last_seen = s;
    track[s.molecule_slot] = t;
  endtask

  task automatic compare_record(input record_t got);
    record_t want;
    if (records_due.size() == 0) begin
      report_mismatch($sformatf("record with none outstanding: %p", got));
      return;
    end
    want = records_due.pop_front();
    check_field("record_kind", 32'(got.record_kind), 32'(want.record_kind));
    check_field("event_time", 32'(got.event_time), 32'(want.event_time));
    check_field("event_x", got.event_x, want.event_x);
    check_field("event_y", got.event_y, want.event_y);
    check_field("event_z", got.event_z, want.event_z);
    check_field("event_vx", got.event_vx, want.event_vx);
    check_field("event_vy", got.event_vy, want.event_vy);
    check_field("event_vz", got.event_vz, want.event_vz);
    check_field("penetration_min", got.penetration_min, want.penetration_min);
    check_field("last", 32'(got.last), 32'(want.last));
  endtask

  always @(posedge clk) begin
    if (rst) begin
      for (int i = 0; i < NUM_SLOTS; i++) track[i] = '0;
      cut_level = CUT_HEIGHT_INIT;
      records_due.delete();
    end else begin
      // A record leaving on this edge can never belong to the request taken on it.
      if (out_valid && out_ready) compare_record(out_data);
      if (cfg_we) cut_level = cfg_wdata;
      if (in_valid && in_ready) predict_records(in_data);
    end
    records_owed <= records_due.size();
  end

endmodule

// ----- tb/sv/tb_wall_collision_event_tracker_top.sv -----
// Top of the wall collision event tracker testbench: clock, reset, requests and verdict.
// Depends on wcet_pkg, wall_collision_event_tracker_top and wcet_event_checker.
module tb_wall_collision_event_tracker_top;
  timeunit 1ns;
  timeprecision 1ps;
  import wcet_pkg::*;

  localparam int IDLE_PCT      = 26;
  localparam int HOLD_CYCLES   = 300;
  localparam int SETTLE_CYCLES = 8;
  localparam int FILL_RANDOM   = 0;
  localparam int FILL_MIN      = 1;
  localparam int FILL_MAX      = 2;
  localparam logic signed [31:0] Z_MIN = 32'sh8000_0000;
  localparam logic signed [31:0] Z_MAX = 32'sh7FFF_FFFF;

  logic               clk       = 1'b0;
  logic               rst       = 1'b1;
  logic               cfg_we    = 1'b0;
  logic [31:0]        cfg_wdata = '0;
  logic               in_valid  = 1'b0;
  logic               in_ready;
  sample_t            in_data   = '0;
  logic               out_valid;
  logic               out_ready = 1'b0;
  record_t            out_data;
  int                 mismatches;
  int                 records_owed;
  logic signed [31:0] cut_now     = CUT_HEIGHT_INIT;
  logic               steady      = 1'b0;
  logic               hold_asked  = 1'b0;
  logic [23:0]        frame_clock = '0;
  logic [11:0]        slot_pool [12];

  always begin
    #5 clk = 1'b1;
    #5 clk = 1'b0;
  end

  wall_collision_event_tracker_top DUT (
    .clk       (clk),
    .rst       (rst),
    .cfg_we    (cfg_we),
    .cfg_wdata (cfg_wdata),
    .in_valid  (in_valid),
    .in_ready  (in_ready),
    .in_data   (in_data),
    .out_valid (out_valid),
    .out_ready (out_ready),
    .out_data  (out_data)
  );

  wcet_event_checker u_checker (
    .clk          (clk),
    .rst          (rst),
    .cfg_we       (cfg_we),
    .cfg_wdata    (cfg_wdata),
    .in_valid     (in_valid),
    .in_ready     (in_ready),
    .in_data      (in_data),
    .out_valid    (out_valid),
    .out_ready    (out_ready),
    .out_data     (out_data),
    .mismatches   (mismatches),
    .records_owed (records_owed)
  );

  // Record sink: random stalls, none while steady, and one long hold-off on demand.
  initial begin
    forever begin
      @(posedge clk);
      if (hold_asked) begin
        hold_asked = 1'b0;
        out_ready <= 1'b0;
        repeat (HOLD_CYCLES) @(posedge clk);
      end else begin
        out_ready <= steady || ($urandom_range(0, 99) >= IDLE_PCT);
      end
    end
  end

  initial begin
    #2_000_000;
    $display("tb_wall_collision_event_tracker_top: done, errors");
    $finish;
  end

  function automatic sample_t make_sample(input logic [11:0] slot, input logic [3:0] sp,
                                          input logic first, input logic [23:0] ft,
                                          input logic signed [31:0] z, input int fill);
    sample_t s;
    s.molecule_slot = slot;
    s.species       = sp;
    s.first_frame   = first;
    s.frame_time    = ft;
    s.pos_z         = z;
    case (fill)
      FILL_MIN: begin
        s.pos_x = Z_MIN; s.pos_y = Z_MIN; s.vel_x = Z_MIN; s.vel_y = Z_MIN; s.vel_z = Z_MIN;
      end
      FILL_MAX: begin
        s.pos_x = Z_MAX; s.pos_y = Z_MAX; s.vel_x = Z_MAX; s.vel_y = Z_MAX; s.vel_z = Z_MAX;
      end
      default: begin
        s.pos_x = $urandom; s.pos_y = $urandom;
        s.vel_x = $urandom; s.vel_y = $urandom; s.vel_z = $urandom;
      end
    endcase
    return s;
  endfunction

  // A height just at or above the cutoff, or just below it, clipped to the Q16.16 range.
  function automatic logic signed [31:0] near_cut(input logic want_above);
    longint c;
    longint lo;
    longint hi;
    c = cut_now;
    if (want_above) begin
      lo = c;
      hi = (c + 4000 > 64'sd2147483647) ? 64'sd2147483647 : c + 4000;
    end else begin
      if (c == -64'sd2147483648) return $urandom;
      hi = c - 1;
      lo = (c - 4000 < -64'sd2147483648) ? -64'sd2147483648 : c - 4000;
    end
    return 32'(lo + longint'($urandom_range(0, int'(hi - lo))));
  endfunction

  task automatic send_sample(input sample_t s);
    while (!steady && $urandom_range(0, 99) < IDLE_PCT) begin
      in_valid <= 1'b0;
      @(posedge clk);
    end
    in_valid <= 1'b1;
    in_data  <= s;
    do @(posedge clk); while (!in_ready);
  endtask

  // Hold requests back until every record has left, then let any update finish.
  task automatic drain_and_settle();
    in_valid <= 1'b0;
    do @(posedge clk); while (records_owed != 0);
    repeat (SETTLE_CYCLES) @(posedge clk);
  endtask

  task automatic write_cut(input logic signed [31:0] v);
    cfg_we    <= 1'b1;
    cfg_wdata <= v;
    cut_now    = v;
    @(posedge clk);
    cfg_we    <= 1'b0;
  endtask

  // Random trajectories over a small pool of slots, so that molecules dip and rise often.
  task automatic run_random(input int gas_items, input int hold_at, input int steady_for);
    int                 gas_sent;
    int                 pick;
    int                 fill;
    logic signed [31:0] z;
    sample_t            s;
    gas_sent = 0;
    slot_pool[0] = 12'd0;
    slot_pool[1] = 12'hFFF;
    for (int i = 2; i < 12; i++) slot_pool[i] = 12'($urandom);
    while (gas_sent < gas_items) begin
      steady = (gas_sent < steady_for);
      pick = $urandom_range(0, 99);
      if (pick < 45)      z = near_cut(1'b1);
      else if (pick < 90) z = near_cut(1'b0);
      else if (pick < 95) z = $urandom;
      else if (pick < 97) z = cut_now;
      else                z = (pick == 97) ? Z_MIN : Z_MAX;
      pick = $urandom_range(0, 99);
      fill = (pick < 2) ? FILL_MIN : (pick < 4) ? FILL_MAX : FILL_RANDOM;
      frame_clock += 24'($urandom_range(1, 3));
      s = make_sample(($urandom_range(0, 19) == 0) ? 12'($urandom)
                                                   : slot_pool[$urandom_range(0, 11)],
                      ($urandom_range(0, 99) < 8) ? 4'($urandom) : GAS_SPECIES,
                      $urandom_range(0, 19) == 0,
                      ($urandom_range(0, 49) == 0) ? 24'($urandom) : frame_clock,
                      z, fill);
      send_sample(s);
      if (s.species == GAS_SPECIES) begin
        gas_sent++;
        if (gas_sent == hold_at) hold_asked = 1'b1;
      end
    end
    steady = 1'b0;
  endtask

  initial begin
    repeat (9) @(posedge clk);
    rst <= 1'b0;

    // Slot 0: start at the cutoff, dip to the bottom of the range, rise to the top.
    send_sample(make_sample(12'd0, GAS_SPECIES, 1'b1, 24'd0, cut_now, FILL_RANDOM));
    send_sample(make_sample(12'd0, GAS_SPECIES, 1'b0, 24'd1, cut_now - 1, FILL_RANDOM));
    send_sample(make_sample(12'd0, GAS_SPECIES, 1'b0, 24'd2, Z_MIN, FILL_MIN));
    send_sample(make_sample(12'd0, 4'd0, 1'b0, 24'd3, cut_now + 5, FILL_RANDOM));
    send_sample(make_sample(12'd0, 4'hF, 1'b0, 24'd3, Z_MAX, FILL_MAX));
    send_sample(make_sample(12'd0, GAS_SPECIES, 1'b0, 24'd4, 32'sd5, FILL_RANDOM));
    send_sample(make_sample(12'd0, GAS_SPECIES, 1'b0, 24'hFFFFFF, Z_MAX, FILL_MAX));
    // Slot 4095: rise with no collision open, then repeated first frames inside a dip.
    send_sample(make_sample(12'hFFF, GAS_SPECIES, 1'b0, 24'hFFFFFF, cut_now + 1, FILL_MIN));
    send_sample(make_sample(12'hFFF, GAS_SPECIES, 1'b0, 24'd1, cut_now - 100, FILL_RANDOM));
    send_sample(make_sample(12'hFFF, GAS_SPECIES, 1'b1, 24'd2, cut_now - 7, FILL_RANDOM));
    send_sample(make_sample(12'hFFF, GAS_SPECIES, 1'b1, 24'd3, cut_now + 7, FILL_RANDOM));
    send_sample(make_sample(12'hFFF, GAS_SPECIES, 1'b0, 24'd4, -32'sd1, FILL_RANDOM));
    send_sample(make_sample(12'hFFF, GAS_SPECIES, 1'b0, 24'd5, cut_now, FILL_RANDOM));
    // Slot 7: below from the start, so rising gives no records.
    send_sample(make_sample(12'd7, GAS_SPECIES, 1'b0, 24'd0, -32'sd5, FILL_RANDOM));
    send_sample(make_sample(12'd7, GAS_SPECIES, 1'b0, 24'd1, cut_now + 3, FILL_RANDOM));
    send_sample(make_sample(12'hAAA, GAS_SPECIES, 1'b1, 24'd0, Z_MAX, FILL_MAX));
    send_sample(make_sample(12'hAAA, GAS_SPECIES, 1'b0, 24'd1, Z_MIN, FILL_MIN));
    send_sample(make_sample(12'hAAA, GAS_SPECIES, 1'b0, 24'd2, cut_now, FILL_RANDOM));
    send_sample(make_sample(12'h555, GAS_SPECIES, 1'b0, 24'd0, 32'sd0, FILL_RANDOM));
    send_sample(make_sample(12'h555, GAS_SPECIES, 1'b0, 24'd1, cut_now, FILL_RANDOM));
    send_sample(make_sample(12'd0, GAS_SPECIES, 1'b0, 24'd0, cut_now + 1, FILL_RANDOM));

    run_random(300, 60, 0);
    drain_and_settle();
    write_cut(32'sd0);
    run_random(280, -1, 0);
    drain_and_settle();
    // At the lowest cutoff everything counts as above; at the highest only the top value.
    write_cut(Z_MIN);
    run_random(140, -1, 0);
    drain_and_settle();
    write_cut(Z_MAX);
    run_random(140, -1, 0);
    drain_and_settle();
    write_cut($urandom);
    run_random(380, -1, 200);
    drain_and_settle();
    write_cut(-32'sd655360);
    run_random(360, 250, 0);
    drain_and_settle();

    if (mismatches == 0) begin
      $display("tb_wall_collision_event_tracker_top: done, clean");
    end else begin
      $display("tb_wall_collision_event_tracker_top: done, errors");
    end
    $finish;
  end

endmodule
